[sv/bie_pkg.sv]
// ----------------------------------------------------------------------------
// bie_pkg: shared definitions of the IR executor
// Tape geometry, instruction opcodes and the tape access structs that pass
// between the execute core and the top level.
// ----------------------------------------------------------------------------
package bie_pkg;

  // Number of tape cells; a power of two so that cell addresses wrap by
  // truncation.
  localparam int TAPE_CELLS = 32768;
  localparam int ADDR_W     = $clog2(TAPE_CELLS);
  localparam int CELL_W     = 8;

  // Width used for pointer and address sums before they wrap to ADDR_W.
  localparam int SUM_W = ((ADDR_W > 16) ? ADDR_W : 16) + 1;

  // Instruction opcodes.
  typedef enum logic [3:0] {
    OP_PTR_ADD  = 4'd0,
    OP_PTR_SUB  = 4'd1,
    OP_CELL_ADD = 4'd2,
    OP_CELL_SUB = 4'd3,
    OP_PUT      = 4'd4,
    OP_GET      = 4'd5,
    OP_LABEL    = 4'd6,
    OP_JUMP     = 4'd7,
    OP_ASSIGN   = 4'd8,
    OP_MULADD   = 4'd9,
    OP_MULSUB   = 4'd10,
    OP_HALT     = 4'd11
  } op_e;

  // Read request to the tape: the cell at the pointer and the addressed cell.
  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr_z;
    logic [ADDR_W-1:0] addr_c;
  } tape_rd_t;

  // Write request to the tape.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } tape_wr_t;

endpackage

[sv/bie_tape_ram.sv]
// ----------------------------------------------------------------------------
// bie_tape_ram: tape memory
// One write port and two read ports; read data is registered and holds its
// value while the read enable is low. A read of the entry being written in
// the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module bie_tape_ram #(
  parameter int DEPTH = 32768,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

[sv/bie_core.sv]
// ----------------------------------------------------------------------------
// bie_core: instruction pipeline of the IR executor
// Stage one takes an instruction word, updates the data pointer and halt flag
// and issues the tape reads. Stage two gets the read data, forwards the cell
// written as its reads issued, computes the result and writes the tape back.
// An output register holds the result word until it is taken.
// ----------------------------------------------------------------------------
module bie_core
  import bie_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                run_i,
  // Instruction words
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,   // operand_a[15:0], cell_offset, in_byte
  input  logic [3:0]          s_axis_tuser,   // opcode
  // Result words
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // next_pc[15:0], out_byte, halted, zero fill
  output logic [0:0]          m_axis_tuser,   // out_valid
  // Tape access
  output tape_rd_t            rd_o,
  input  logic [CELL_W-1:0]   rdata_z_i,
  input  logic [CELL_W-1:0]   rdata_c_i,
  output tape_wr_t            wr_o
);

  // Input decode.
  op_e         in_op;
  logic [15:0] in_a;
  logic [15:0] in_b;
  logic [7:0]  in_byte;
  logic        accept;

  assign in_op   = op_e'(s_axis_tuser);
  assign in_a    = s_axis_tdata[15:0];
  assign in_b    = s_axis_tdata[31:16];
  assign in_byte = s_axis_tdata[39:32];

  // Pipeline control.
  logic e_valid_q, e_fire;
  logic o_valid_q;

  assign e_fire        = e_valid_q && (!o_valid_q || m_axis_tready);
  assign s_axis_tready = run_i && (!e_valid_q || e_fire);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Stage one: pointer, halt flag and cell address.
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic              halt_q, halt_d;
  logic [SUM_W-1:0]  ptr_ext, b_ext, a_ext, addr_sum, add_sum, sub_sum;
  logic [ADDR_W-1:0] cell_addr;

  assign ptr_ext   = {{(SUM_W-ADDR_W){1'b0}}, ptr_q};
  assign b_ext     = {{(SUM_W-16){in_b[15]}}, in_b};
  assign a_ext     = {{(SUM_W-16){1'b0}}, in_a};
  assign addr_sum  = ptr_ext + b_ext;
  assign add_sum   = ptr_ext + a_ext;
  assign sub_sum   = ptr_ext - a_ext;
  assign cell_addr = addr_sum[ADDR_W-1:0];

  always_comb begin
    ptr_d  = ptr_q;
    halt_d = halt_q;
    if (accept && !halt_q) begin
      unique case (in_op)
        OP_PTR_ADD: ptr_d  = add_sum[ADDR_W-1:0];
        OP_PTR_SUB: ptr_d  = sub_sum[ADDR_W-1:0];
        OP_HALT:    halt_d = 1'b1;
        default:    ptr_d  = ptr_q;
      endcase
    end
  end

  assign rd_o.re     = accept;
  assign rd_o.addr_z = ptr_q;
  assign rd_o.addr_c = cell_addr;

  // Forwarding: the write leaving stage two in this cycle is not yet
  // visible to the reads issued in the same cycle.
  logic fwd_z_d, fwd_c_d;
  assign fwd_z_d = wr_o.we && (wr_o.addr == ptr_q);
  assign fwd_c_d = wr_o.we && (wr_o.addr == cell_addr);

  // Stage two registers.
  op_e               e_op_q;
  logic [15:0]       e_a_q;
  logic [7:0]        e_byte_q;
  logic [ADDR_W-1:0] e_addr_q;
  logic [ADDR_W-1:0] e_dp_q;
  logic              e_ign_q;
  logic              e_halted_q;
  logic              fwd_z_q, fwd_c_q;
  logic [CELL_W-1:0] fwd_data_q;
  logic [15:0]       pc_q;
  logic [15:0]       next_pc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      halt_q    <= 1'b0;
      e_valid_q <= 1'b0;
      pc_q      <= '0;
    end else begin
      ptr_q  <= ptr_d;
      halt_q <= halt_d;
      if (accept) begin
        e_valid_q <= 1'b1;
      end else if (e_fire) begin
        e_valid_q <= 1'b0;
      end
      if (e_fire) begin
        pc_q <= next_pc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      e_op_q     <= in_op;
      e_a_q      <= in_a;
      e_byte_q   <= in_byte;
      e_addr_q   <= cell_addr;
      e_dp_q     <= ptr_q;
      e_ign_q    <= halt_q;
      e_halted_q <= halt_d;
      fwd_z_q    <= fwd_z_d;
      fwd_c_q    <= fwd_c_d;
      fwd_data_q <= wr_o.data;
    end
  end

  // Stage two: execute.
  logic [CELL_W-1:0] z, c;
  logic [15:0]       prod;
  logic              put_valid;
  logic [CELL_W-1:0] put_byte;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;

  assign z    = fwd_z_q ? fwd_data_q : rdata_z_i;
  assign c    = fwd_c_q ? fwd_data_q : rdata_c_i;
  assign prod = 16'(z) * 16'(e_a_q[7:0]);

  always_comb begin
    next_pc   = pc_q + 16'd1;
    put_valid = 1'b0;
    put_byte  = '0;
    wr_en     = 1'b0;
    wr_addr   = e_addr_q;
    wr_data   = c;
    if (e_ign_q) begin
      next_pc = pc_q;
    end else begin
      unique case (e_op_q)
        OP_CELL_ADD: begin
          wr_en   = 1'b1;
          wr_data = c + e_a_q[7:0];
        end
        OP_CELL_SUB: begin
          wr_en   = 1'b1;
          wr_data = c - e_a_q[7:0];
        end
        OP_PUT: begin
          put_valid = 1'b1;
          put_byte  = c;
        end
        OP_GET: begin
          wr_en   = 1'b1;
          wr_data = e_byte_q;
        end
        OP_LABEL: begin
          if (z == '0) begin
            next_pc = e_a_q;
          end
        end
        OP_JUMP: begin
          next_pc = e_a_q;
        end
        OP_ASSIGN: begin
          wr_en   = 1'b1;
          wr_addr = e_dp_q;
          wr_data = e_a_q[7:0];
        end
        OP_MULADD: begin
          wr_en   = 1'b1;
          wr_data = c + prod[7:0];
        end
        OP_MULSUB: begin
          wr_en   = 1'b1;
          wr_data = c - prod[7:0];
        end
        OP_HALT: begin
          next_pc = pc_q;
        end
        default: begin
          next_pc = pc_q + 16'd1;
        end
      endcase
    end
  end

  assign wr_o.we   = e_fire && wr_en;
  assign wr_o.addr = wr_addr;
  assign wr_o.data = wr_data;

  // Output register.
  logic [31:0] o_data_q;
  logic        o_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (e_fire) begin
      o_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_fire) begin
      o_data_q <= {7'd0, e_halted_q, put_byte, next_pc};
      o_user_q <= put_valid;
    end
  end

  assign m_axis_tvalid   = o_valid_q;
  assign m_axis_tdata    = o_data_q;
  assign m_axis_tuser[0] = o_user_q;

endmodule

[sv/brainfuck_ir_executor.sv]
// ----------------------------------------------------------------------------
// brainfuck_ir_executor: optimized IR instruction executor
// Executes one IR instruction per input word against a byte tape and returns
// one result word per instruction.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes instruction words: tuser carries the opcode, tdata
// carries operand_a, cell_offset and in_byte. The master channel returns one
// word per instruction with the next program counter, the emitted byte and
// the halt status in tdata, and tuser set when the byte comes from a put.
// The result word passes the stage-two registers and then the output
// register before it shows on the master side. The block takes one
// word every cycle while the receiver keeps up: the tape reads of a word
// issue as it is accepted, and the write of the previous word is forwarded
// from the tape write port, so the dual-read tape memory sets the rate.
// After reset the tape is swept to zero, one cell per cycle, over all
// TAPE_CELLS (32768) cells; tready stays low until the sweep is done.
// When the receiver stalls, the output register holds its word, one more
// word can enter the execute stage, and then tready drops.
// ----------------------------------------------------------------------------
module brainfuck_ir_executor
  import bie_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // operand_a[15:0], cell_offset[31:16], in_byte[39:32]
  input  logic [3:0]  s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // next_pc[15:0], out_byte[23:16], halted[24], zeros
  output logic [0:0]  m_axis_tuser    // out_valid
);

  tape_rd_t          rd;
  tape_wr_t          core_wr;
  tape_wr_t          ram_wr;
  logic [CELL_W-1:0] rdata_z, rdata_c;

  // Clearing sweep after reset.
  logic              clr_active_q, clr_active_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;

  always_comb begin
    clr_active_d = clr_active_q;
    clr_addr_d   = clr_addr_q;
    if (clr_active_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(TAPE_CELLS - 1)) begin
        clr_active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_addr_q   <= clr_addr_d;
    end
  end

  // Tape write port: the sweep owns it until the tape is clear.
  always_comb begin
    if (clr_active_q) begin
      ram_wr.we   = 1'b1;
      ram_wr.addr = clr_addr_q;
      ram_wr.data = '0;
    end else begin
      ram_wr = core_wr;
    end
  end

  bie_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .run_i         (!clr_active_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .rd_o          (rd),
    .rdata_z_i     (rdata_z),
    .rdata_c_i     (rdata_c),
    .wr_o          (core_wr)
  );

  bie_tape_ram #(
    .DEPTH (TAPE_CELLS),
    .WIDTH (CELL_W)
  ) u_tape (
    .clk_i     (clk_i),
    .we_i      (ram_wr.we),
    .waddr_i   (ram_wr.addr),
    .wdata_i   (ram_wr.data),
    .re_i      (rd.re),
    .raddr_a_i (rd.addr_z),
    .raddr_b_i (rd.addr_c),
    .rdata_a_o (rdata_z),
    .rdata_b_o (rdata_c)
  );

endmodule
